// ----- rtl/core/swd_pkg.sv -----
// Shared constants and register map of the stereo width and delay block.
`default_nettype none

package swd_pkg;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_WIDTH_GAIN    = 2'd0;
  localparam reg_idx_t REG_SURROUND_GAIN = 2'd1;
  localparam reg_idx_t REG_DELAY_LEN     = 2'd2;
  localparam reg_idx_t REG_BYPASS        = 2'd3;

  // register field widths
  localparam int WG_W = 11;
  localparam int SG_W = 9;
  localparam int DF_W = 13;

  localparam logic [WG_W-1:0] WG_RESET = 11'd256;

  // Q8 gain shifts and rounding offsets
  localparam int WIDEN_SHIFT = 9;
  localparam int SURR_SHIFT  = 8;
  localparam int WIDEN_ROUND = 256;
  localparam int SURR_ROUND  = 128;

endpackage

`default_nettype wire

// ----- rtl/core/swd_in_if.sv -----
// Input frame channel: valid/ready with one stereo frame per beat.
`default_nettype none

interface swd_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;
  logic                           last_frame;

  modport source (output valid, left_in, right_in, last_frame, input ready);
  modport sink   (input valid, left_in, right_in, last_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swd_out_if.sv -----
// Output frame channel: valid/ready with one processed stereo frame per beat.
`default_nettype none

interface swd_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic                           last_out;

  modport source (output valid, left_out, right_out, last_out, input ready);
  modport sink   (input valid, left_out, right_out, last_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/stereo_width_and_delay.sv -----
// Stereo widener with ring delay line (plain delay or surround mode).
//
//   channel   dir  beat contents
//   in_ch     in   left_in, right_in, last_frame
//   out_ch    out  left_out, right_out, last_out
//   apb       in   width_gain, surround_gain, delay_len, bypass
//
// One frame per cycle sustained unless out_ch stalls or a clear or reduction runs.
// The rate is set by the single delay memory: one read and, unless bypassed, one write
// per frame. After reset the delay memory is cleared with in_ch.ready low.
// A write of delay_len starts a modulo reduction; in_ch.ready is low meanwhile.
// A stalled output fills the five-stage pipeline; input stalls on it only once it is full.
`default_nettype none

module stereo_width_and_delay #(
  parameter int DELAY_DEPTH  = 8192,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  swd_in_if.sink                           in_ch,
  swd_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [swd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [swd_pkg::DATA_W-1:0]  pwdata,
  output logic      [swd_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int AW   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int SUMW = SW + 14;
  localparam int PW   = SW + 10;

  localparam logic [AW-1:0]    LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]      DEPTH_X   = (AW + 1)'(DELAY_DEPTH);
  localparam logic [31:0]      DEPTH32   = 32'(DELAY_DEPTH);
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'($signed({1'b0, {(SW-1){1'b1}}}));
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  // quotient by depth: floor(x * RECIP / 2^RSH), exact for every 13-bit x
  localparam int          RSH   = swd_pkg::DF_W + AW;
  localparam logic [31:0] RECIP = 32'(((64'd1 << RSH) + 64'(DELAY_DEPTH) - 64'd1)
                                      / 64'(DELAY_DEPTH));

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [SUMW-1:0] x);
    logic signed [SW-1:0] res;
    if (x > SAT_HI) begin
      res = SAT_HI[SW-1:0];
    end else if (x < SAT_LO) begin
      res = SAT_LO[SW-1:0];
    end else begin
      res = x[SW-1:0];
    end
    return res;
  endfunction

  // ---------------- configuration ----------------
  logic [swd_pkg::WG_W-1:0] width_gain;
  logic [swd_pkg::SG_W-1:0] surround_gain;
  logic [swd_pkg::DF_W-1:0] delay_len;
  logic                     bypass;

  logic [swd_pkg::DF_W-1:0] mod_rem;
  logic [swd_pkg::DF_W-1:0] mod_q;
  logic                     mod_busy;
  logic                     mod_ph;
  logic [31:0]              mod_prod;
  logic [31:0]              mod_back;

  swd_pkg::reg_idx_t        cfg_idx;
  logic                     cfg_we;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[3:2];
  assign cfg_we   = psel && penable && pwrite && pready;
  assign mod_prod = 32'(delay_len) * RECIP;
  assign mod_back = 32'(mod_q) * DEPTH32;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_gain    <= swd_pkg::WG_RESET;
      surround_gain <= '0;
      delay_len     <= '0;
      bypass        <= 1'b0;
      mod_rem       <= '0;
      mod_q         <= '0;
      mod_busy      <= 1'b0;
      mod_ph        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          swd_pkg::REG_WIDTH_GAIN:    width_gain    <= pwdata[swd_pkg::WG_W-1:0];
          swd_pkg::REG_SURROUND_GAIN: surround_gain <= pwdata[swd_pkg::SG_W-1:0];
          swd_pkg::REG_DELAY_LEN:     delay_len     <= pwdata[swd_pkg::DF_W-1:0];
          swd_pkg::REG_BYPASS:        bypass        <= pwdata[0];
          default: ;
        endcase
      end
      // quotient first, then remainder = delay - quotient * depth
      if (cfg_we && cfg_idx == swd_pkg::REG_DELAY_LEN) begin
        mod_busy <= 1'b1;
        mod_ph   <= 1'b0;
      end else if (mod_busy) begin
        if (!mod_ph) begin
          mod_q  <= swd_pkg::DF_W'(mod_prod >> RSH);
          mod_ph <= 1'b1;
        end else begin
          mod_rem  <= swd_pkg::DF_W'(32'(delay_len) - mod_back);
          mod_busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      swd_pkg::REG_WIDTH_GAIN:    prdata = swd_pkg::DATA_W'(width_gain);
      swd_pkg::REG_SURROUND_GAIN: prdata = swd_pkg::DATA_W'(surround_gain);
      swd_pkg::REG_DELAY_LEN:     prdata = swd_pkg::DATA_W'(delay_len);
      swd_pkg::REG_BYPASS:        prdata = swd_pkg::DATA_W'(bypass);
      default:                    prdata = '0;
    endcase
  end

  logic [AW-1:0] dmod;
  logic          surr;
  assign dmod = AW'(mod_rem);
  assign surr = (surround_gain != '0);

  // ---------------- clearing pass ----------------
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == LAST_ADDR) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // ---------------- pipeline control ----------------
  logic v1, v2, v3, v4, out_v;
  logic en1, en2, en3, en4, en5;
  logic in_fire;

  assign en5      = !out_v || out_ch.ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ch.ready = en1 && !clr_active && !mod_busy;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (en1) v1    <= in_fire;
      if (en2) v2    <= v1;
      if (en3) v3    <= v2;
      if (en4) v4    <= v3;
      if (en5) out_v <= v4;
    end
  end

  // ---------------- write pointer and read address ----------------
  logic [AW-1:0] ptr;
  logic [AW:0]   rp_diff;
  logic [AW-1:0] rp_new;

  assign rp_diff = {1'b0, ptr} - {1'b0, dmod};
  assign rp_new  = rp_diff[AW] ? AW'(rp_diff + DEPTH_X) : rp_diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (in_fire && !bypass) begin
      ptr <= (ptr == LAST_ADDR) ? '0 : ptr + AW'(1);
    end
  end

  // stage 1: captured frame
  logic signed [SW-1:0] s1_l, s1_r;
  logic                 s1_last, s1_byp, s1_self;
  logic [AW-1:0]        s1_wp, s1_rp;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_l    <= in_ch.left_in;
      s1_r    <= in_ch.right_in;
      s1_last <= in_ch.last_frame;
      s1_byp  <= bypass;
      s1_wp   <= ptr;
      s1_rp   <= rp_new;
      s1_self <= (dmod == '0);
    end
  end

  // stage 2: center sum and side product
  logic signed [SUMW-1:0] l_x, r_x;
  logic signed [SUMW-1:0] s2_s, s2_p;
  logic signed [SW-1:0]   s2_l, s2_r;
  logic                   s2_last, s2_byp, s2_self;
  logic [AW-1:0]          s2_wp, s2_rp;

  assign l_x = SUMW'(s1_l);
  assign r_x = SUMW'(s1_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_s    <= ((l_x + r_x) <<< 8) + SUMW'(swd_pkg::WIDEN_ROUND);
      s2_p    <= (l_x - r_x) * SUMW'($signed({1'b0, width_gain}));
      s2_l    <= s1_l;
      s2_r    <= s1_r;
      s2_last <= s1_last;
      s2_byp  <= s1_byp;
      s2_self <= s1_self;
      s2_wp   <= s1_wp;
      s2_rp   <= s1_rp;
    end
  end

  // stage 3: widened pair, delay read result, write-back value
  logic signed [SW-1:0] s3_lw, s3_rw, s3_l, s3_r;
  logic                 s3_last, s3_byp, s3_self;
  logic [AW-1:0]        s3_wp;
  logic                 s3_fwd;
  logic signed [SW-1:0] s3_fwdd;
  logic signed [SW:0]   mid_sum;
  logic signed [SW:0]   mid_sh;
  logic signed [SW-1:0] own, dl;
  logic signed [PW-1:0] prod_c;
  logic                 pipe_we, rd_en;
  logic signed [SW-1:0] mem_q;

  assign mid_sum = (SW + 1)'(s3_lw) + (SW + 1)'(s3_rw);
  assign mid_sh  = mid_sum >>> 1;
  assign own     = surr ? mid_sh[SW-1:0] : s3_rw;
  assign dl      = s3_self ? own : (s3_fwd ? s3_fwdd : mem_q);
  assign prod_c  = PW'(dl) * PW'($signed({1'b0, surround_gain}));

  assign pipe_we = en4 && v3 && !s3_byp;
  assign rd_en   = en3 && v2;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_lw   <= sat_sw((s2_s + s2_p) >>> swd_pkg::WIDEN_SHIFT);
      s3_rw   <= sat_sw((s2_s - s2_p) >>> swd_pkg::WIDEN_SHIFT);
      s3_l    <= s2_l;
      s3_r    <= s2_r;
      s3_last <= s2_last;
      s3_byp  <= s2_byp;
      s3_self <= s2_self;
      s3_wp   <= s2_wp;
      // the frame ahead writes at this same edge; the memory returns old data
      s3_fwd  <= pipe_we && (s3_wp == s2_rp);
      s3_fwdd <= own;
    end
  end

  // delay memory: one write port, one registered read port
  logic signed [SW-1:0] mem [DELAY_DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic signed [SW-1:0] mem_wd;

  assign mem_we = clr_active || pipe_we;
  assign mem_wa = clr_active ? clr_addr : s3_wp;
  assign mem_wd = clr_active ? '0 : own;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en)  mem_q       <= mem[s2_rp];
  end

  // stage 4: surround product
  logic signed [SW-1:0] s4_lw, s4_rw, s4_dl, s4_l, s4_r;
  logic signed [PW-1:0] s4_prod;
  logic                 s4_last, s4_byp;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_lw   <= s3_lw;
      s4_rw   <= s3_rw;
      s4_dl   <= dl;
      s4_prod <= prod_c;
      s4_l    <= s3_l;
      s4_r    <= s3_r;
      s4_last <= s3_last;
      s4_byp  <= s3_byp;
    end
  end

  // stage 5: output register
  logic signed [PW-1:0] amt;
  logic signed [SW-1:0] lo, ro;

  assign amt = (s4_prod + PW'(swd_pkg::SURR_ROUND)) >>> swd_pkg::SURR_SHIFT;

  always_comb begin
    if (s4_byp) begin
      lo = s4_l;
      ro = s4_r;
    end else if (surr) begin
      lo = sat_sw(SUMW'(s4_lw) + SUMW'(amt));
      ro = sat_sw(SUMW'(s4_rw) - SUMW'(amt));
    end else begin
      lo = s4_lw;
      ro = s4_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_ch.left_out  <= lo;
      out_ch.right_out <= ro;
      out_ch.last_out  <= s4_last;
    end
  end

  assign out_ch.valid = out_v;

  // ---------------- checks ----------------
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !(v1 || v2 || v3 || v4 || out_v))
    else $error("frames in flight during delay memory clear");

  a_clear_no_pipe_write: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !pipe_we)
    else $error("pipeline write during delay memory clear");

  a_ptr_on_accept: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(ptr))
    else $error("write pointer moved without an input beat");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    mod_busy |-> !in_fire)
    else $error("input beat taken during delay reduction");

endmodule

`default_nettype wire

// ----- tb/sv/stereo_width_and_delay_tb.sv -----
// Self-checking testbench for the stereo width and delay block.
module stereo_width_and_delay_tb;

  localparam int SW = 16;
  localparam int DEPTH = 8192;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } frame_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [swd_pkg::ADDR_W-1:0] paddr;
  logic [swd_pkg::DATA_W-1:0] pwdata;
  logic [swd_pkg::DATA_W-1:0] prdata;
  logic pready;

  swd_in_if #(.SAMPLE_WIDTH(SW)) in_ch();
  swd_out_if #(.SAMPLE_WIDTH(SW)) out_ch();

  stereo_width_and_delay #(
    .DELAY_DEPTH(DEPTH),
    .SAMPLE_WIDTH(SW)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // shadow registers and delay store of the predictor
  logic [swd_pkg::WG_W-1:0] cfg_width;
  logic [swd_pkg::SG_W-1:0] cfg_surround;
  logic [swd_pkg::DF_W-1:0] cfg_delay;
  logic cfg_bypass;
  logic signed [SW-1:0] haas_line [DEPTH];
  logic [swd_pkg::DF_W-1:0] haas_wr;

  frame_t frames_to_send[$];
  frame_t frames_due[$];
  int mismatch_count;
  bit steady;

  function automatic logic signed [SW-1:0] clip(longint x);
    if (x > SMAX) return SW'(SMAX);
    if (x < SMIN) return SW'(SMIN);
    return SW'(x);
  endfunction

  function automatic frame_t widen_and_delay(frame_t f);
    frame_t res;
    longint l, r, g, lw, rw, mid, amt;
    logic [swd_pkg::DF_W-1:0] rd;
    res = f;
    if (cfg_bypass) return res;
    l = longint'($signed(f.left));
    r = longint'($signed(f.right));
    g = longint'(cfg_width);
    lw = clip(((l + r) * 256 + (l - r) * g + 256) >>> 9);
    rw = clip(((l + r) * 256 + (r - l) * g + 256) >>> 9);
    rd = haas_wr - cfg_delay;
    if (cfg_surround != '0) begin
      mid = (lw + rw) >>> 1;
      haas_line[haas_wr] = SW'(mid);
      amt = (longint'(haas_line[rd]) * longint'(cfg_surround) + 128) >>> 8;
      lw = clip(lw + amt);
      rw = clip(rw - amt);
    end else begin
      // plain delay: widened right goes in, delayed entry comes out
      haas_line[haas_wr] = SW'(rw);
      rw = longint'(haas_line[rd]);
    end
    haas_wr = haas_wr + 1'b1;
    res.left = SW'(lw);
    res.right = SW'(rw);
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic cfg_write(swd_pkg::reg_idx_t idx, int unsigned value);
    int unsigned mask;
    case (idx)
      swd_pkg::REG_WIDTH_GAIN:    mask = (1 << swd_pkg::WG_W) - 1;
      swd_pkg::REG_SURROUND_GAIN: mask = (1 << swd_pkg::SG_W) - 1;
      swd_pkg::REG_DELAY_LEN:     mask = (1 << swd_pkg::DF_W) - 1;
      default:                    mask = 1;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    // junk above the field checks the masking
    pwdata <= ($urandom & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      swd_pkg::REG_WIDTH_GAIN:    cfg_width = swd_pkg::WG_W'(value);
      swd_pkg::REG_SURROUND_GAIN: cfg_surround = swd_pkg::SG_W'(value);
      swd_pkg::REG_DELAY_LEN:     cfg_delay = swd_pkg::DF_W'(value);
      default:                    cfg_bypass = value[0];
    endcase
  endtask

  // delay written last: its modulo pass holds in_ch.ready low for a while
  task automatic apply_config(int unsigned wg, int unsigned sg, int unsigned df, bit byp);
    cfg_write(swd_pkg::REG_WIDTH_GAIN, wg);
    cfg_write(swd_pkg::REG_SURROUND_GAIN, sg);
    cfg_write(swd_pkg::REG_BYPASS, byp);
    cfg_write(swd_pkg::REG_DELAY_LEN, df);
  endtask

  task automatic wait_drained();
    while (frames_to_send.size() != 0 || in_ch.valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SW'(SMAX);
      1: return SW'(SMIN);
      2: return SW'(int'($urandom_range(0, 32)) - 16);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    frame_t f;
    repeat (n) begin
      f.left = rand_sample();
      // now and then a pure-mid or pure-side frame
      case ($urandom_range(0, 9))
        0: f.right = f.left;
        1: f.right = -f.left;
        default: f.right = rand_sample();
      endcase
      f.last = $urandom_range(0, 1);
      frames_to_send = {frames_to_send, f};
    end
  endtask

  task automatic queue_corners();
    logic signed [SW-1:0] lv [12];
    logic signed [SW-1:0] rv [12];
    frame_t f;
    lv = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
           16'sh0001, 16'shffff, 16'sh4000, 16'sh3039, 16'sh0000, 16'sh8000};
    rv = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
           16'shffff, 16'sh0000, 16'shc000, 16'sha460, 16'sh7fff, 16'sh0000};
    for (int i = 0; i < 12; i++) begin
      f.left = lv[i];
      f.right = rv[i];
      f.last = i[0];
      frames_to_send = {frames_to_send, f};
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // input driver; the predictor runs on every accepted beat
  always @(posedge clk) begin
    frame_t sent;
    frame_t nxt;
    frame_t exp_f;
    bit gap;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sent.left = in_ch.left_in;
        sent.right = in_ch.right_in;
        sent.last = in_ch.last_frame;
        exp_f = widen_and_delay(sent);
        frames_due = {frames_due, exp_f};
      end
      if (!in_ch.valid || in_ch.ready) begin
        gap = !steady && ($urandom_range(0, 99) < 24);
        if (frames_to_send.size() != 0 && !gap) begin
          nxt = frames_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.left_in <= nxt.left;
          in_ch.right_in <= nxt.right;
          in_ch.last_frame <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frames_due.size() == 0) begin
          flag_mismatch("output beat with nothing expected");
        end else begin
          want = frames_due.pop_front();
          if (out_ch.left_out !== want.left)
            flag_mismatch($sformatf("left_out %0d, expected %0d", out_ch.left_out, want.left));
          if (out_ch.right_out !== want.right)
            flag_mismatch($sformatf("right_out %0d, expected %0d", out_ch.right_out,
                                    want.right));
          if (out_ch.last_out !== want.last)
            flag_mismatch($sformatf("last_out %0b, expected %0b", out_ch.last_out, want.last));
        end
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    in_ch.last_frame = 1'b0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    steady = 1'b0;
    cfg_width = swd_pkg::WG_RESET;
    cfg_surround = '0;
    cfg_delay = '0;
    cfg_bypass = 1'b0;
    haas_wr = '0;
    foreach (haas_line[i]) haas_line[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // delay store clear runs first
    do @(posedge clk); while (!in_ch.ready);

    // reset values: unity width, zero delay reads back this frame
    queue_corners();
    wait_drained();
    // gains at their field maximum, one-frame surround
    apply_config(2047, 511, 1, 1'b0);
    queue_corners();
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: apply_config(0, 256, 0, 1'b0);
        1: apply_config(1024, 256, 3, 1'b0);
        2: apply_config(256, 0, 8191, 1'b1);
        3: apply_config(2047, 1, 8191, 1'b0);
        default: begin
          int unsigned wg, sg, df;
          case ($urandom_range(0, 4))
            0: wg = 0;
            1: wg = 256;
            2: wg = 1024;
            3: wg = 2047;
            default: wg = $urandom_range(0, 2047);
          endcase
          case ($urandom_range(0, 5))
            0, 1: sg = 0;
            2: sg = 256;
            3: sg = 511;
            default: sg = $urandom_range(1, 511);
          endcase
          case ($urandom_range(0, 5))
            0: df = 0;
            1: df = 1;
            2: df = 8191;
            3: df = $urandom_range(0, 40);
            default: df = $urandom_range(0, 1000);
          endcase
          apply_config(wg, sg, df, $urandom_range(0, 7) == 0);
        end
      endcase
      steady = (p == 4);
      if (p == 1) begin
        // sender holds off until the pipe is empty, then resumes
        queue_random(40);
        wait_drained();
        queue_random(45);
      end else begin
        queue_random(85);
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
